FILE: src/dfa_text_matcher_defines.svh
// assertion macros used by the matcher engine rtl
// no dependencies; taken in by dtm_engine.sv, which carries concurrent assertions
`ifndef DFA_TEXT_MATCHER_DEFINES_SVH
`define DFA_TEXT_MATCHER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define DTM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define DTM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/dtm_pkg.sv
// shared sizes, codes and types of the automaton text matcher
// no dependencies
`default_nettype none

package dtm_pkg;

    localparam int STATE_COUNT  = 256;
    localparam int SYMBOL_COUNT = 256;

    localparam int FIELD_W      = 8;
    localparam int ACC_ADDR_W   = $clog2(STATE_COUNT);
    localparam int TRANS_DEPTH  = STATE_COUNT * SYMBOL_COUNT;
    localparam int TRANS_ADDR_W = $clog2(TRANS_DEPTH);
    localparam int ENTRY_W      = FIELD_W + 1;

    localparam logic [1:0] CMD_TRANS  = 2'd0;
    localparam logic [1:0] CMD_ACCEPT = 2'd1;
    localparam logic [1:0] CMD_TEXT   = 2'd2;
    localparam logic [1:0] CMD_EMPTY  = 2'd3;

    localparam logic [1:0] CAUSE_ACCEPT  = 2'd0;
    localparam logic [1:0] CAUSE_MISSING = 2'd1;
    localparam logic [1:0] CAUSE_END     = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [FIELD_W-1:0] state_index;
        logic [FIELD_W-1:0] symbol;
        logic [FIELD_W-1:0] next_state;
        logic               entry_valid;
        logic               first_byte;
        logic               last_byte;
    } t_item;

    typedef struct packed {
        logic       emit;
        logic       verdict;
        logic [1:0] cause;
    } t_result;

endpackage

`default_nettype wire

FILE: src/dtm_ram.sv
// generic simple dual-port ram with registered read
// no dependencies
`default_nettype none

module dtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/dtm_engine.sv
// sequencer of the matcher: clearing sweep, loads and the per-byte walk
// depends on dtm_pkg, dtm_ram and dfa_text_matcher_defines.svh
`default_nettype none
`include "dfa_text_matcher_defines.svh"

module dtm_engine (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_mode,
    input  wire logic            i_valid,
    input  wire dtm_pkg::t_item  i_item,
    input  wire logic            i_out_free,
    output logic                 o_ready,
    output dtm_pkg::t_result     o_res
);
    import dtm_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_RD_T  = 2'd2;
    localparam logic [1:0] S_RD_A  = 2'd3;

    localparam logic [TRANS_ADDR_W-1:0] CLR_LAST = TRANS_ADDR_W'(TRANS_DEPTH - 1);

    logic [1:0]              r_state, n_state;
    logic [TRANS_ADDR_W-1:0] r_clr, n_clr;
    logic [FIELD_W-1:0]      r_cur, n_cur;
    logic                    r_decided, n_decided;
    logic                    r_last, n_last;
    logic                    r_next_ok, n_next_ok;
    logic                    r_acc0, n_acc0;
    logic [STATE_COUNT-1:0]  r_vbits, n_vbits;

    logic                    t_we;
    logic [TRANS_ADDR_W-1:0] t_waddr, t_raddr;
    logic [ENTRY_W-1:0]      t_wdata, t_rdata;
    logic                    a_we;
    logic [ACC_ADDR_W-1:0]   a_waddr, a_raddr;
    logic [0:0]              a_wdata, a_rdata;

    logic                    take;
    logic                    eff_decided;
    logic [FIELD_W-1:0]      eff_cur;
    logic                    sidx_ok, sym_ok, cur_ok, acc_hit;

    dtm_ram #(.WIDTH(ENTRY_W), .DEPTH(TRANS_DEPTH)) u_trans_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    dtm_ram #(.WIDTH(1), .DEPTH(STATE_COUNT)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    assign o_ready = (r_state == S_IDLE) && i_out_free;
    assign take    = o_ready && i_valid;

    // a first byte restarts the walk from state 0
    assign eff_decided = i_item.first_byte ? 1'b0 : r_decided;
    assign eff_cur     = i_item.first_byte ? '0 : r_cur;

    assign sidx_ok = int'(i_item.state_index) < STATE_COUNT;
    assign sym_ok  = int'(i_item.symbol) < SYMBOL_COUNT;
    assign cur_ok  = int'(eff_cur) < STATE_COUNT;
    assign acc_hit = r_next_ok && a_rdata[0] && r_vbits[ACC_ADDR_W'(r_cur)];

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_cur     = r_cur;
        n_decided = r_decided;
        n_last    = r_last;
        n_next_ok = r_next_ok;
        n_acc0    = r_acc0;
        n_vbits   = r_vbits;
        t_we      = 1'b0;
        t_waddr   = TRANS_ADDR_W'(int'(i_item.state_index) * SYMBOL_COUNT
                                  + int'(i_item.symbol));
        t_wdata   = {i_item.entry_valid, i_item.next_state};
        t_raddr   = TRANS_ADDR_W'(int'(eff_cur) * SYMBOL_COUNT + int'(i_item.symbol));
        a_we      = 1'b0;
        a_waddr   = ACC_ADDR_W'(i_item.state_index);
        a_wdata   = i_item.entry_valid;
        a_raddr   = ACC_ADDR_W'(t_rdata[FIELD_W-1:0]);
        o_res     = '0;
        case (r_state)
            S_CLEAR: begin
                t_we    = 1'b1;
                t_waddr = r_clr;
                t_wdata = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (take) begin
                    case (i_item.cmd)
                        CMD_TRANS: begin
                            t_we = sidx_ok && sym_ok;
                        end
                        CMD_ACCEPT: begin
                            if (sidx_ok) begin
                                a_we = 1'b1;
                                n_vbits[ACC_ADDR_W'(i_item.state_index)] = 1'b1;
                                if (i_item.state_index == '0) begin
                                    n_acc0 = i_item.entry_valid;
                                end
                            end
                        end
                        CMD_EMPTY: begin
                            n_cur         = '0;
                            n_decided     = 1'b1;
                            o_res.emit    = 1'b1;
                            o_res.verdict = i_mode && r_acc0;
                            o_res.cause   = (i_mode && r_acc0) ? CAUSE_ACCEPT : CAUSE_END;
                        end
                        default: begin
                            if (!eff_decided) begin
                                n_cur     = eff_cur;
                                n_decided = 1'b0;
                                n_last    = i_item.last_byte;
                                if (cur_ok && sym_ok) begin
                                    n_state = S_RD_T;
                                end else begin
                                    n_decided   = 1'b1;
                                    o_res.emit  = 1'b1;
                                    o_res.cause = CAUSE_MISSING;
                                end
                            end
                        end
                    endcase
                end
            end
            S_RD_T: begin
                if (!t_rdata[FIELD_W]) begin
                    n_decided   = 1'b1;
                    o_res.emit  = 1'b1;
                    o_res.cause = CAUSE_MISSING;
                    n_state     = S_IDLE;
                end else begin
                    n_cur     = t_rdata[FIELD_W-1:0];
                    n_next_ok = int'(t_rdata[FIELD_W-1:0]) < STATE_COUNT;
                    n_state   = S_RD_A;
                end
            end
            S_RD_A: begin
                n_state = S_IDLE;
                if (acc_hit && (!i_mode || r_last)) begin
                    n_decided     = 1'b1;
                    o_res.emit    = 1'b1;
                    o_res.verdict = 1'b1;
                    o_res.cause   = CAUSE_ACCEPT;
                end else if (r_last) begin
                    n_decided   = 1'b1;
                    o_res.emit  = 1'b1;
                    o_res.cause = CAUSE_END;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_cur     <= '0;
            r_decided <= 1'b0;
            r_acc0    <= 1'b0;
            r_vbits   <= '0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_cur     <= n_cur;
            r_decided <= n_decided;
            r_acc0    <= n_acc0;
            r_vbits   <= n_vbits;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last    <= n_last;
        r_next_ok <= n_next_ok;
    end

    `DTM_ASSERT_NOW(a_no_take_in_clear, i_clk, i_rst_n, r_state == S_CLEAR, !o_ready,
                    "request taken during clearing sweep")
    `DTM_ASSERT_NOW(a_emit_when_owned, i_clk, i_rst_n, o_res.emit,
                    (r_state == S_RD_T) || (r_state == S_RD_A) || take,
                    "result produced with no request in flight")
    `DTM_ASSERT_NOW(a_match_cause, i_clk, i_rst_n, o_res.emit && o_res.verdict,
                    o_res.cause == CAUSE_ACCEPT, "match verdict with a reject cause")
    `DTM_ASSERT_NEXT(a_rdt_follow, i_clk, i_rst_n, r_state == S_RD_T,
                     (r_state == S_RD_A) || (r_state == S_IDLE),
                     "transition read not followed by flag read or idle")
    `DTM_ASSERT_NEXT(a_walk_starts, i_clk, i_rst_n,
                     take && (i_item.cmd == CMD_TEXT) && !eff_decided && cur_ok && sym_ok,
                     r_state == S_RD_T, "text byte did not start a transition read")

endmodule

`default_nettype wire

FILE: src/dfa_text_matcher.sv
// loads are written in the cycle they are taken; an empty text gives its result in the
// cycle after the request; a deciding byte gives its result after the transition memory
// read and, for a valid entry, the dependent accept flag read; loads are taken back to
// back while the output slot is free; a text byte blocks requests until those reads end
// reset: synchronous active low; a clearing pass over STATE_COUNT*SYMBOL_COUNT (65536)
// entries clears the transition memory with o_in_stall high; config writes still taken
`default_nettype none

module dfa_text_matcher (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic                        i_cfg_wr_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [1:0]                  i_cmd,
    input  wire logic [dtm_pkg::FIELD_W-1:0] i_state_index,
    input  wire logic [dtm_pkg::FIELD_W-1:0] i_symbol,
    input  wire logic [dtm_pkg::FIELD_W-1:0] i_next_state,
    input  wire logic                        i_entry_valid,
    input  wire logic                        i_first_byte,
    input  wire logic                        i_last_byte,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_verdict,
    output logic [1:0]                       o_cause
);
    import dtm_pkg::*;

    logic       r_mode;
    logic       r_out_valid;
    logic       r_verdict;
    logic [1:0] r_cause;
    logic       out_free;
    logic       ready;
    t_item      item;
    t_result    res;

    assign item = '{cmd: i_cmd, state_index: i_state_index, symbol: i_symbol,
                    next_state: i_next_state, entry_valid: i_entry_valid,
                    first_byte: i_first_byte, last_byte: i_last_byte};

    // output slot is free when empty or being drained this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    dtm_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_mode),
        .i_valid    (i_in_valid),
        .i_item     (item),
        .i_out_free (out_free),
        .o_ready    (ready),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (res.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.emit) begin
            r_verdict <= res.verdict;
            r_cause   <= res.cause;
        end
    end

    assign o_in_stall  = !ready;
    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;
    assign o_cause     = r_cause;

endmodule

`default_nettype wire

FILE: test/dfa_text_matcher_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the automaton text matcher dfa_text_matcher
// depends on dtm_pkg (src/dtm_pkg.sv) and the matcher rtl; keeps its own model of the automaton
module dfa_text_matcher_tb;
    import dtm_pkg::*;

    localparam int WATCHDOG_LIMIT = 300000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 6;
    localparam int AUTO_STATES    = 6;
    localparam int AUTO_SYMS      = 6;

    typedef struct packed {
        logic       verdict;
        logic [1:0] cause;
    } t_verdict_rec;

    logic  clk         = 1'b0;
    logic  rst_n       = 1'b0;
    logic  cfg_wr_en   = 1'b0;
    logic  cfg_wr_data = 1'b0;
    logic  in_valid    = 1'b0;
    logic  out_stall   = 1'b0;
    t_item req         = '0;

    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_verdict;
    logic [1:0] o_cause;

    // mirror of the matcher state
    bit [ENTRY_W-1:0] trans_mem [TRANS_DEPTH];
    bit               acc_flag [STATE_COUNT];
    logic [7:0]       cur_state = 8'h00;
    bit               decided = 1'b0;
    bit               mode_whole = 1'b0;

    t_verdict_rec verdict_q[$];
    int           mismatch_count = 0;
    int           sent_count = 0;
    int           idle_cycles = 0;
    int           hold_count = 0;
    bit           src_idle_on = 1'b1;
    bit           sink_idle_on = 1'b1;
    bit           long_hold = 1'b0;

    logic [7:0] auto_states [AUTO_STATES];
    logic [7:0] auto_syms [AUTO_SYMS];

    dfa_text_matcher DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (req.cmd),
        .i_state_index (req.state_index),
        .i_symbol      (req.symbol),
        .i_next_state  (req.next_state),
        .i_entry_valid (req.entry_valid),
        .i_first_byte  (req.first_byte),
        .i_last_byte   (req.last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_verdict     (o_verdict),
        .o_cause       (o_cause)
    );

    always #4 clk = ~clk;

    function automatic t_item make_item(logic [1:0] c, logic [7:0] sidx, logic [7:0] sym,
                                        logic [7:0] nxt, logic ev, logic f, logic l);
        t_item it;
        it.cmd         = c;
        it.state_index = sidx;
        it.symbol      = sym;
        it.next_state  = nxt;
        it.entry_valid = ev;
        it.first_byte  = f;
        it.last_byte   = l;
        return it;
    endfunction

    function automatic void queue_verdict(logic v, logic [1:0] c);
        t_verdict_rec rec;
        rec.verdict = v;
        rec.cause   = c;
        verdict_q = {verdict_q, rec};
    endfunction

    // one accepted request through the automaton
    function automatic void matcher_step(t_item it);
        bit [ENTRY_W-1:0] entry;
        case (it.cmd)
            CMD_TRANS: begin
                trans_mem[{it.state_index, it.symbol}] = {it.entry_valid, it.next_state};
            end
            CMD_ACCEPT: begin
                acc_flag[it.state_index] = it.entry_valid;
            end
            CMD_EMPTY: begin
                cur_state = 8'h00;
                decided = 1'b1;
                if (mode_whole && acc_flag[0]) queue_verdict(1'b1, CAUSE_ACCEPT);
                else queue_verdict(1'b0, CAUSE_END);
            end
            default: begin
                if (it.first_byte) begin
                    cur_state = 8'h00;
                    decided = 1'b0;
                end
                if (!decided) begin
                    entry = trans_mem[{cur_state, it.symbol}];
                    if (!entry[ENTRY_W-1]) begin
                        decided = 1'b1;
                        queue_verdict(1'b0, CAUSE_MISSING);
                    end else begin
                        cur_state = entry[FIELD_W-1:0];
                        if (acc_flag[cur_state] && (!mode_whole || it.last_byte)) begin
                            decided = 1'b1;
                            queue_verdict(1'b1, CAUSE_ACCEPT);
                        end else if (it.last_byte) begin
                            decided = 1'b1;
                            queue_verdict(1'b0, CAUSE_END);
                        end
                    end
                end
            end
        endcase
    endfunction

    task automatic send_request(input t_item it);
        while (src_idle_on && $urandom_range(0, 99) < 19) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        req <= it;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        matcher_step(it);
        sent_count++;
    endtask

    // sender goes quiet until every verdict is back and the pipe has settled
    task automatic wait_for_verdicts();
        @(negedge clk);
        in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_match_mode(input bit whole);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= whole;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        mode_whole = whole;
    endtask

    task automatic build_automaton();
        auto_states[0] = 8'h00;
        for (int i = 1; i < AUTO_STATES; i++) auto_states[i] = 8'($urandom_range(0, 255));
        foreach (auto_syms[j]) auto_syms[j] = 8'($urandom_range(0, 255));
        foreach (auto_states[i]) begin
            foreach (auto_syms[j]) begin
                send_request(make_item(CMD_TRANS, auto_states[i], auto_syms[j],
                                       auto_states[$urandom_range(0, AUTO_STATES-1)],
                                       $urandom_range(0, 99) < 75, 1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1))));
            end
        end
        foreach (auto_states[i]) begin
            send_request(make_item(CMD_ACCEPT, auto_states[i], 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), $urandom_range(0, 99) < 30,
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        end
    endtask

    // mostly strings that walk existing transitions, with some noise and broken framing
    task automatic send_random_string();
        int         pick;
        int         len;
        logic [7:0] walk;
        logic [7:0] sym;
        logic       f;
        logic       l;
        bit [ENTRY_W-1:0] entry;
        logic [7:0] opts[$];
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            send_request(make_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1))));
            return;
        end
        if (pick < 9) begin
            send_request(make_item(CMD_EMPTY, 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1))));
            return;
        end
        len = $urandom_range(1, 10);
        walk = 8'h00;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < 4) begin
                // a load in the middle of a string leaves the string alone
                send_request(make_item($urandom_range(0, 1) ? CMD_TRANS : CMD_ACCEPT,
                                       auto_states[$urandom_range(0, AUTO_STATES-1)],
                                       auto_syms[$urandom_range(0, AUTO_SYMS-1)],
                                       auto_states[$urandom_range(0, AUTO_STATES-1)],
                                       $urandom_range(0, 99) < 70, 1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1))));
            end
            opts.delete();
            foreach (auto_syms[j]) begin
                if (trans_mem[{walk, auto_syms[j]}][ENTRY_W-1]) opts = {opts, auto_syms[j]};
            end
            if (opts.size() > 0 && $urandom_range(0, 99) < 88)
                sym = opts[$urandom_range(0, opts.size()-1)];
            else if ($urandom_range(0, 1))
                sym = auto_syms[$urandom_range(0, AUTO_SYMS-1)];
            else
                sym = 8'($urandom_range(0, 255));
            entry = trans_mem[{walk, sym}];
            if (entry[ENTRY_W-1]) walk = entry[FIELD_W-1:0];
            f = (k == 0) && ($urandom_range(0, 99) >= 4);
            l = (k == len-1) && ($urandom_range(0, 99) >= 4);
            send_request(make_item(CMD_TEXT, 8'($urandom_range(0, 255)), sym,
                                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                   f, l));
        end
    endtask

    // stores are clear after reset, state 0 is where an unframed byte starts
    task automatic test_after_reset();
        write_match_mode(1'b0);
        send_request(make_item(CMD_TEXT, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
        send_request(make_item(CMD_EMPTY, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_prefix_directed();
        send_request(make_item(CMD_TRANS, 8'h00, 8'h61, 8'h01, 1'b1, 1'b0, 1'b0));
        send_request(make_item(CMD_TRANS, 8'h01, 8'h62, 8'h02, 1'b1, 1'b0, 1'b0));
        send_request(make_item(CMD_ACCEPT, 8'h02, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
        send_request(make_item(CMD_TRANS, 8'h00, 8'hff, 8'hff, 1'b1, 1'b1, 1'b1));
        send_request(make_item(CMD_TRANS, 8'hff, 8'hff, 8'h00, 1'b1, 1'b0, 1'b0));
        send_request(make_item(CMD_ACCEPT, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, 1'b1));
        // "ab" accepts, then "aba" accepts at b and drops the trailing a
        send_request(make_item(CMD_TEXT, 8'h00, 8'h61, 8'h00, 1'b0, 1'b1, 1'b0));
        send_request(make_item(CMD_TEXT, 8'h00, 8'h62, 8'h00, 1'b0, 1'b0, 1'b1));
        send_request(make_item(CMD_TEXT, 8'hff, 8'h61, 8'hff, 1'b1, 1'b1, 1'b0));
        send_request(make_item(CMD_TEXT, 8'hff, 8'h62, 8'hff, 1'b1, 1'b0, 1'b0));
        send_request(make_item(CMD_TEXT, 8'hff, 8'h61, 8'hff, 1'b1, 1'b0, 1'b1));
        // missing transition mid string
        send_request(make_item(CMD_TEXT, 8'h00, 8'h61, 8'h00, 1'b0, 1'b1, 1'b0));
        send_request(make_item(CMD_TEXT, 8'h00, 8'h78, 8'h00, 1'b0, 1'b0, 1'b1));
        send_request(make_item(CMD_TEXT, 8'h00, 8'hff, 8'h00, 1'b0, 1'b1, 1'b1));
        // ends in a non-accepting state
        send_request(make_item(CMD_TEXT, 8'h00, 8'h61, 8'h00, 1'b0, 1'b1, 1'b1));
        // entry written with its valid bit clear
        send_request(make_item(CMD_TRANS, 8'h00, 8'h7a, 8'h05, 1'b0, 1'b0, 1'b0));
        send_request(make_item(CMD_TEXT, 8'h00, 8'h7a, 8'h00, 1'b0, 1'b1, 1'b1));
        // restart before the string ends, with a load in between
        send_request(make_item(CMD_TEXT, 8'h00, 8'h61, 8'h00, 1'b0, 1'b1, 1'b0));
        send_request(make_item(CMD_TEXT, 8'h00, 8'h61, 8'h00, 1'b0, 1'b1, 1'b0));
        send_request(make_item(CMD_ACCEPT, 8'h07, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
        send_request(make_item(CMD_TEXT, 8'h00, 8'h62, 8'h00, 1'b0, 1'b0, 1'b1));
    endtask

    task automatic test_whole_directed();
        wait_for_verdicts();
        write_match_mode(1'b1);
        send_request(make_item(CMD_TEXT, 8'h00, 8'h61, 8'h00, 1'b0, 1'b1, 1'b0));
        send_request(make_item(CMD_TEXT, 8'h00, 8'h62, 8'h00, 1'b0, 1'b0, 1'b1));
        // passes through an accepting state, ends in one
        send_request(make_item(CMD_TRANS, 8'h02, 8'h63, 8'h01, 1'b1, 1'b0, 1'b0));
        send_request(make_item(CMD_TEXT, 8'h00, 8'h61, 8'h00, 1'b0, 1'b1, 1'b0));
        send_request(make_item(CMD_TEXT, 8'h00, 8'h62, 8'h00, 1'b0, 1'b0, 1'b0));
        send_request(make_item(CMD_TEXT, 8'h00, 8'h63, 8'h00, 1'b0, 1'b0, 1'b0));
        send_request(make_item(CMD_TEXT, 8'h00, 8'h62, 8'h00, 1'b0, 1'b0, 1'b1));
        // passes through an accepting state, ends outside one
        send_request(make_item(CMD_TEXT, 8'h00, 8'h61, 8'h00, 1'b0, 1'b1, 1'b0));
        send_request(make_item(CMD_TEXT, 8'h00, 8'h62, 8'h00, 1'b0, 1'b0, 1'b0));
        send_request(make_item(CMD_TEXT, 8'h00, 8'h63, 8'h00, 1'b0, 1'b0, 1'b1));
        // empty text against state 0 flag, then an unframed byte stays ignored
        send_request(make_item(CMD_EMPTY, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
        send_request(make_item(CMD_TEXT, 8'h00, 8'h61, 8'h00, 1'b0, 1'b0, 1'b1));
        send_request(make_item(CMD_ACCEPT, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
        send_request(make_item(CMD_EMPTY, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, 1'b1));
        send_request(make_item(CMD_TEXT, 8'h00, 8'hff, 8'h00, 1'b0, 1'b1, 1'b0));
        send_request(make_item(CMD_TEXT, 8'h00, 8'hff, 8'h00, 1'b0, 1'b0, 1'b1));
        send_request(make_item(CMD_ACCEPT, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_random_strings(input bit whole, input bit quiet, input int n_items);
        int stop_at;
        wait_for_verdicts();
        src_idle_on = !quiet;
        sink_idle_on = !quiet;
        write_match_mode(whole);
        stop_at = sent_count + n_items;
        build_automaton();
        while (sent_count < stop_at) send_random_string();
    endtask

    // receiver holds off long enough for the matcher to back up into its input
    task automatic test_output_backpressure();
        int stop_at;
        wait_for_verdicts();
        long_hold = 1'b1;
        stop_at = sent_count + 120;
        while (sent_count < stop_at) send_random_string();
        long_hold = 1'b0;
    endtask

    // sender waits for every verdict before each burst
    task automatic test_sender_pause();
        wait_for_verdicts();
        write_match_mode(1'b1);
        for (int b = 0; b < 4; b++) begin
            repeat (6) send_random_string();
            wait_for_verdicts();
        end
    endtask

    always @(posedge clk) begin
        t_verdict_rec want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (verdict_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, got verdict %0d cause %0d",
                         $time, o_verdict, o_cause);
            end else begin
                want = verdict_q.pop_front();
                if (o_verdict !== want.verdict) begin
                    mismatch_count++;
                    $display("%0t: verdict mismatch, expected %0d, got %0d",
                             $time, want.verdict, o_verdict);
                end
                if (o_cause !== want.cause) begin
                    mismatch_count++;
                    $display("%0t: cause mismatch, expected %0d, got %0d",
                             $time, want.cause, o_cause);
                end
            end
        end
    end

    always @(negedge clk) begin
        if (long_hold && hold_count < HOLD_CYCLES) begin
            hold_count++;
            out_stall <= 1'b1;
        end else begin
            if (!long_hold) hold_count = 0;
            out_stall <= sink_idle_on && ($urandom_range(0, 99) < 19);
        end
    end

    // covers the clearing pass after reset with room to spare
    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        test_after_reset();
        test_prefix_directed();
        test_whole_directed();
        test_random_strings(1'b0, 1'b0, 340);
        test_random_strings(1'b1, 1'b1, 340);
        test_output_backpressure();
        test_random_strings(1'b0, 1'b0, 350);
        test_sender_pause();
        test_random_strings(1'b1, 1'b0, 350);
        wait_for_verdicts();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
